// File: rtl/cam_pkg.sv
// Package for the calendar minute adder: shared types, constants and the
// calendar helper functions. No dependencies.
package cam_pkg;

  localparam int unsigned MAX_ADD_MINUTES = 59400;

  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned WeekdayW = 3;
  localparam int unsigned AddW     = 32;
  // Counts that can take effect fit in 16 bits.
  localparam int unsigned CountW   = 16;
  localparam int unsigned DaysW    = 6;
  localparam int unsigned RestW    = 11;
  localparam int unsigned Q25W     = 10;

  // Reciprocal constants: floor(x * R >> S) equals x / D over the used range.
  localparam logic [10:0] RecipDays  = 11'd1457;  // (count >> 5) / 45
  localparam logic [11:0] RecipHours = 12'd2185;  // rest / 60, shift 17
  localparam logic [12:0] Recip25    = 13'd5243;  // year / 25, shift 17

  localparam int unsigned FifoDepth = 2;

  localparam logic [MonthW-1:0] December = 4'd12;
  localparam logic [MonthW-1:0] February = 4'd2;

  typedef logic [DayW-1:0] month_len_t [13];
  localparam month_len_t MonthLen = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [YearW-1:0]    year;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
    logic [WeekdayW-1:0] weekday;
    logic [DaysW-1:0]    days;
    logic                applied;
  } cam_item_t;

  typedef enum logic [2:0] {
    F_IDLE, F_DAYS, F_REST, F_HOURS, F_MINS, F_CARRY, F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE, B_WALK, B_DONE
  } back_state_e;

  // Gregorian leap test, given the year and a precomputed floor(year / 25).
  function automatic logic is_leap(logic [YearW-1:0] year, logic [Q25W-1:0] q25);
    logic [YearW-1:0] times25;
    logic div4, div16, div25;
    times25 = YearW'({q25, 4'b0}) + YearW'({q25, 3'b0}) + YearW'(q25);
    div4    = (year[1:0] == 2'b0);
    div16   = (year[3:0] == 4'b0);
    div25   = (times25 == year);
    return div4 && (!div25 || div16);
  endfunction

  // Month length; months outside 1..12 are 31 days long.
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] month, logic leap);
    logic [DayW-1:0] len;
    len = 5'd31;
    if (month == February) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (month >= 4'd1 && month <= December) begin
      len = MonthLen[month];
    end
    return len;
  endfunction

endpackage

// File: rtl/calendar_add_minutes.sv
// Top level of the calendar minute adder: front end, item queue, back end.
// Depends on cam_pkg, cam_front, cam_fifo and cam_back.
//
// Usage: the input side is a queue write port. A transfer happens at a
// rising edge with push high and full low; it carries a date and time and
// a signed minute count. The result side is a queue read port: while empty
// is low the oldest result sits on the new_* and applied_o ports, and a
// transfer happens at an edge with pop high.
// Flow: the front end takes an item and then, for a count from 1 to the
// maximum, splits it into days, hours and minutes with their carries in the
// states F_DAYS, F_REST, F_HOURS, F_MINS and F_CARRY before it writes the
// two-entry queue. A count out of range goes straight to the queue and
// comes back unchanged. The back end loads an item and then walks the date
// one day per cycle, D days with D up to 42, before the item shows up on the
// result side. The front end takes no new item until it has written the
// last one to the queue.
// Reset clears both state machines and the queue; nothing is waiting
// afterwards. If the receiver does not pop, the back end holds its result,
// the queue fills and full then stays high until results are taken.
module calendar_add_minutes #(
  parameter int unsigned MaxAddMinutes = cam_pkg::MAX_ADD_MINUTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [cam_pkg::YearW-1:0]        year_i,
  input  logic [cam_pkg::MonthW-1:0]       month_i,
  input  logic [cam_pkg::DayW-1:0]         day_i,
  input  logic [cam_pkg::HourW-1:0]        hour_i,
  input  logic [cam_pkg::MinuteW-1:0]      minute_i,
  input  logic [cam_pkg::WeekdayW-1:0]     weekday_i,
  input  logic signed [cam_pkg::AddW-1:0]  add_minutes_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [cam_pkg::YearW-1:0]        new_year_o,
  output logic [cam_pkg::MonthW-1:0]       new_month_o,
  output logic [cam_pkg::DayW-1:0]         new_day_o,
  output logic [cam_pkg::HourW-1:0]        new_hour_o,
  output logic [cam_pkg::MinuteW-1:0]      new_minute_o,
  output logic [cam_pkg::WeekdayW-1:0]     new_weekday_o,
  output logic                             applied_o
);
  import cam_pkg::*;

  // Classified items travel from the front end to the queue.
  cam_item_t front_item;
  logic      front_push;
  logic      fifo_full;

  // The back end drains the queue one item at a time.
  cam_item_t back_item;
  logic      back_pop;
  logic      fifo_empty;

  cam_front #(
    .MaxAddMinutes(MaxAddMinutes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .year_i       (year_i),
    .month_i      (month_i),
    .day_i        (day_i),
    .hour_i       (hour_i),
    .minute_i     (minute_i),
    .weekday_i    (weekday_i),
    .add_minutes_i(add_minutes_i),
    .fifo_push_o  (front_push),
    .fifo_item_o  (front_item),
    .fifo_full_i  (fifo_full)
  );

  cam_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .item_i (front_item),
    .full_o (fifo_full),
    .pop_i  (back_pop),
    .item_o (back_item),
    .empty_o(fifo_empty)
  );

  cam_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_item_i  (back_item),
    .fifo_empty_i (fifo_empty),
    .fifo_pop_o   (back_pop),
    .empty        (empty),
    .pop          (pop),
    .new_year_o   (new_year_o),
    .new_month_o  (new_month_o),
    .new_day_o    (new_day_o),
    .new_hour_o   (new_hour_o),
    .new_minute_o (new_minute_o),
    .new_weekday_o(new_weekday_o),
    .applied_o    (applied_o)
  );

endmodule

// File: rtl/cam_front.sv
// Front end of the calendar minute adder: accepts an item, checks the count
// and splits it into days, hours and minutes with carries. Uses cam_pkg.
module cam_front #(
  parameter int unsigned MaxAddMinutes = cam_pkg::MAX_ADD_MINUTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [cam_pkg::YearW-1:0]         year_i,
  input  logic [cam_pkg::MonthW-1:0]        month_i,
  input  logic [cam_pkg::DayW-1:0]          day_i,
  input  logic [cam_pkg::HourW-1:0]         hour_i,
  input  logic [cam_pkg::MinuteW-1:0]       minute_i,
  input  logic [cam_pkg::WeekdayW-1:0]      weekday_i,
  input  logic signed [cam_pkg::AddW-1:0]   add_minutes_i,
  output logic                              fifo_push_o,
  output cam_pkg::cam_item_t                fifo_item_o,
  input  logic                              fifo_full_i
);
  import cam_pkg::*;

  front_state_e      state_q, state_d;
  cam_item_t         item_q, item_d;
  logic [CountW-1:0] count_q, count_d;
  logic [RestW-1:0]  rest_q, rest_d;
  logic [HourW-1:0]  hours_q, hours_d;
  logic [MinuteW-1:0] mins_q, mins_d;

  logic              in_range;
  logic [21:0]       days_prod;
  logic [CountW-1:0] rest_full;
  logic [23:0]       hours_prod;
  logic [RestW-1:0]  mins_full;
  logic [6:0]        min_sum;
  logic              min_carry;
  logic [5:0]        hour_sum;
  logic              hour_carry;

  assign in_range = !add_minutes_i[AddW-1] && (add_minutes_i != '0) &&
                    (AddW'(add_minutes_i) <= AddW'(MaxAddMinutes));

  assign full        = (state_q != F_IDLE);
  assign fifo_push_o = (state_q == F_PUSH) && !fifo_full_i;
  assign fifo_item_o = item_q;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    count_d = count_q;
    rest_d  = rest_q;
    hours_d = hours_q;
    mins_d  = mins_q;

    days_prod  = 22'(count_q[CountW-1:5]) * 22'(RecipDays);
    rest_full  = count_q - CountW'(item_q.days) * CountW'(1440);
    hours_prod = 24'(rest_q) * 24'(RecipHours);
    mins_full  = rest_q - RestW'(hours_q) * RestW'(60);
    min_sum    = 7'(item_q.minute) + 7'(mins_q);
    min_carry  = (min_sum >= 7'd60);
    hour_sum   = 6'(item_q.hour) + 6'(hours_q) + 6'(min_carry);
    hour_carry = (hour_sum >= 6'd24);

    unique case (state_q)
      F_IDLE: begin
        if (push) begin
          item_d.year    = year_i;
          item_d.month   = month_i;
          item_d.day     = day_i;
          item_d.hour    = hour_i;
          item_d.minute  = minute_i;
          item_d.weekday = weekday_i;
          item_d.days    = '0;
          item_d.applied = in_range;
          count_d        = add_minutes_i[CountW-1:0];
          state_d        = in_range ? F_DAYS : F_PUSH;
        end
      end
      F_DAYS: begin
        item_d.days = days_prod[21:16];
        state_d     = F_REST;
      end
      F_REST: begin
        rest_d  = rest_full[RestW-1:0];
        state_d = F_HOURS;
      end
      F_HOURS: begin
        hours_d = hours_prod[21:17];
        state_d = F_MINS;
      end
      F_MINS: begin
        mins_d  = mins_full[MinuteW-1:0];
        state_d = F_CARRY;
      end
      F_CARRY: begin
        item_d.minute = min_carry ? 6'(min_sum - 7'd60) : min_sum[MinuteW-1:0];
        item_d.hour   = hour_carry ? 5'(hour_sum - 6'd24) : hour_sum[HourW-1:0];
        item_d.days   = item_q.days + DaysW'(hour_carry);
        // Weekday 7 behaves as 0 under the modulo-7 sum.
        if (item_q.weekday == 3'd7) begin
          item_d.weekday = '0;
        end
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!fifo_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    count_q <= count_d;
    rest_q  <= rest_d;
    hours_q <= hours_d;
    mins_q  <= mins_d;
  end

endmodule

// File: rtl/cam_fifo.sv
// Short queue of classified items between front and back end.
// Uses cam_pkg for the item type and depth.
module cam_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cam_pkg::cam_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output cam_pkg::cam_item_t item_o,
  output logic               empty_o
);
  import cam_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  cam_item_t         mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/cam_back.sv
// Back end of the calendar minute adder: walks the date one day per cycle
// and holds the finished result until it is taken. Uses cam_pkg.
module cam_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cam_pkg::cam_item_t            fifo_item_i,
  input  logic                          fifo_empty_i,
  output logic                          fifo_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [cam_pkg::YearW-1:0]     new_year_o,
  output logic [cam_pkg::MonthW-1:0]    new_month_o,
  output logic [cam_pkg::DayW-1:0]      new_day_o,
  output logic [cam_pkg::HourW-1:0]     new_hour_o,
  output logic [cam_pkg::MinuteW-1:0]   new_minute_o,
  output logic [cam_pkg::WeekdayW-1:0]  new_weekday_o,
  output logic                          applied_o
);
  import cam_pkg::*;

  back_state_e        state_q, state_d;
  logic [DaysW-1:0]   cnt_q, cnt_d;
  cam_item_t          cur_q, cur_d;
  logic [Q25W-1:0]    q25_q;
  logic [26:0]        q25_prod;
  logic               leap;
  logic [DayW-1:0]    len;

  // floor(year / 25) tracks the working year, so the leap flag is always
  // current, also right after a year rollover.
  assign q25_prod = 27'(cur_d.year) * 27'(Recip25);
  assign leap     = is_leap(cur_q.year, q25_q);
  assign len      = month_len(cur_q.month, leap);

  assign empty         = (state_q != B_DONE);
  assign new_year_o    = cur_q.year;
  assign new_month_o   = cur_q.month;
  assign new_day_o     = cur_q.day;
  assign new_hour_o    = cur_q.hour;
  assign new_minute_o  = cur_q.minute;
  assign new_weekday_o = cur_q.weekday;
  assign applied_o     = cur_q.applied;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    fifo_pop_o = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          cur_d      = fifo_item_i;
          cnt_d      = fifo_item_i.days;
          state_d    = (fifo_item_i.days == '0) ? B_DONE : B_WALK;
        end
      end
      B_WALK: begin
        if (cur_q.day >= len) begin
          cur_d.day = 5'd1;
          if (cur_q.month >= December) begin
            cur_d.year  = cur_q.year + 1'b1;
            cur_d.month = 4'd1;
          end else begin
            cur_d.month = cur_q.month + 1'b1;
          end
        end else begin
          cur_d.day = cur_q.day + 1'b1;
        end
        cur_d.weekday = (cur_q.weekday == 3'd6) ? '0 : cur_q.weekday + 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == DaysW'(1)) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (pop) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    q25_q <= q25_prod[26:17];
  end

endmodule
